// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: item layouts,
// command kinds, back-end states and character codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int ROW_FIELD_W = 6;
    localparam int COL_FIELD_W = 8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] RESET_ATTR    = 8'h0F;
    localparam logic [7:0] BLANK_CHAR    = 8'h20;
    localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHR_RETURN    = 8'h0D;
    localparam logic [7:0] CHR_TAB       = 8'h09;
    localparam logic [7:0] CHR_BACKSPACE = 8'h08;
    localparam int         TAB_STEP      = 4;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic REG_ATTR = 1'b0;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] character;
        logic [4:0] target_row;
        logic [6:0] target_column;
    } t_in;

    typedef struct packed {
        logic [4:0]  row_now;
        logic [6:0]  column_now;
        logic [10:0] cursor_position;
        logic [15:0] cell_data;
        logic        scrolled;
    } t_out;

    typedef enum logic [2:0] {
        KIND_PRINT,
        KIND_NEWLINE,
        KIND_RETURN,
        KIND_TAB,
        KIND_BACKSPACE,
        KIND_SET,
        KIND_CLEAR,
        KIND_READ
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             character;
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_queue_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_DRAIN,
        ST_FILL
    } t_state;

endpackage

// ===== rtl/core/tcw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Input side: accepts items, sorts put bytes into command kinds and clamps
// the target cell to the screen.
// ----------------------------------------------------------------------------
module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic          i_valid,
    output logic          o_ready,
    input  t_in           i_item,
    input  t_queue_status i_queue,
    input  logic          i_init_busy,
    output logic          o_push,
    output t_cmd          o_cmd
);

    always_comb begin
        o_ready = !i_queue.full && !i_init_busy;
        o_push  = i_valid && o_ready;

        o_cmd.character = i_item.character;
        o_cmd.row = (32'(i_item.target_row) >= ROWS) ? ROW_FIELD_W'(ROWS - 1)
                                                     : ROW_FIELD_W'(i_item.target_row);
        o_cmd.col = (32'(i_item.target_column) >= COLUMNS) ? COL_FIELD_W'(COLUMNS - 1)
                                                           : COL_FIELD_W'(i_item.target_column);

        case (i_item.operation)
            OP_PUT: begin
                case (i_item.character)
                    CHR_NEWLINE:   o_cmd.kind = KIND_NEWLINE;
                    CHR_RETURN:    o_cmd.kind = KIND_RETURN;
                    CHR_TAB:       o_cmd.kind = KIND_TAB;
                    CHR_BACKSPACE: o_cmd.kind = KIND_BACKSPACE;
                    default:       o_cmd.kind = KIND_PRINT;
                endcase
            end
            OP_SET:   o_cmd.kind = KIND_SET;
            OP_CLEAR: o_cmd.kind = KIND_CLEAR;
            OP_READ:  o_cmd.kind = KIND_READ;
            default:  o_cmd.kind = KIND_READ;
        endcase
    end

endmodule

// ===== rtl/core/tcw_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module tcw_queue
    import tcw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cmd          i_push_cmd,
    input  logic          i_pop,
    output t_cmd          o_cmd,
    output t_queue_status o_status
);

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_cmd           r_data [QUEUE_DEPTH];
    logic [QPW-1:0] r_wptr;
    logic [QPW-1:0] r_rptr;
    logic [QPW:0]   r_count;
    logic [QPW-1:0] n_wptr;
    logic [QPW-1:0] n_rptr;
    logic [QPW:0]   n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_push_cmd;
        end
    end

    assign o_cmd          = r_data[r_rptr];
    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == (QPW + 1)'(QUEUE_DEPTH));

endmodule

// ===== rtl/core/tcw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Execution side: owns the screen memory and the cursor, runs puts, cursor
// moves, cell reads, scroll copies and fill passes, and holds the result.
// ----------------------------------------------------------------------------
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_queue_status i_queue,
    input  t_cmd          i_cmd,
    output logic          o_pop,
    input  logic [7:0]    i_attr,
    output logic          o_init_busy,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_out          o_out_item
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int PW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    logic [15:0]   r_mem [CELLS];
    t_state        r_state;
    t_state        n_state;
    logic [PW-1:0] r_addr;
    logic [PW-1:0] n_addr;
    logic [15:0]   r_fill;
    logic [15:0]   n_fill;
    logic          r_init;
    logic          n_init;
    logic          r_scroll;
    logic          n_scroll;
    logic [15:0]   r_rdata;
    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic          r_out_valid;
    t_out          r_out;

    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [PW-1:0] mem_raddr;
    logic          out_load;
    logic [15:0]   out_cell;
    logic          out_scroll;
    t_out          out_item;
    logic [CW:0]   col_t;
    logic [RW:0]   row_t;
    logic [PW-1:0] pos_cur;
    logic [PW-1:0] pos_next;
    logic [15:0]   blank;

    always_comb begin
        blank   = {i_attr, BLANK_CHAR};
        pos_cur = PW'(PW'(r_row) * PW'(COLUMNS) + PW'(r_col));

        col_t = {1'b0, r_col};
        row_t = {1'b0, r_row};
        case (i_cmd.kind)
            KIND_PRINT: col_t = col_t + 1'b1;
            KIND_NEWLINE: begin
                col_t = '0;
                row_t = row_t + 1'b1;
            end
            KIND_RETURN: col_t = '0;
            KIND_TAB: begin
                col_t = (col_t + (CW + 1)'(TAB_STEP)) & ~((CW + 1)'(TAB_STEP - 1));
            end
            KIND_BACKSPACE: begin
                if (r_col != '0) begin
                    col_t = col_t - 1'b1;
                end
            end
            default: col_t = {1'b0, r_col};
        endcase
        if (32'(col_t) >= COLUMNS) begin
            col_t = '0;
            row_t = row_t + 1'b1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_fill     = r_fill;
        n_init     = r_init;
        n_scroll   = r_scroll;
        n_row      = r_row;
        n_col      = r_col;
        o_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        out_load   = 1'b0;
        out_cell   = '0;
        out_scroll = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_queue.valid && (!r_out_valid || i_out_ready)) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        KIND_SET: begin
                            n_row    = RW'(i_cmd.row);
                            n_col    = CW'(i_cmd.col);
                            out_load = 1'b1;
                        end
                        KIND_CLEAR: begin
                            n_row    = '0;
                            n_col    = '0;
                            n_fill   = blank;
                            n_addr   = '0;
                            n_scroll = 1'b0;
                            n_state  = ST_FILL;
                        end
                        KIND_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = PW'(PW'(i_cmd.row) * PW'(COLUMNS) + PW'(i_cmd.col));
                            n_state   = ST_READ;
                        end
                        default: begin
                            if (i_cmd.kind == KIND_PRINT) begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_cur;
                                mem_wdata = {i_attr, i_cmd.character};
                            end
                            if (32'(row_t) >= ROWS) begin
                                n_row    = RW'(ROWS - 1);
                                n_col    = '0;
                                n_fill   = blank;
                                n_addr   = PW'(COLUMNS);
                                n_scroll = 1'b1;
                                n_state  = ST_COPY;
                            end else begin
                                n_row    = RW'(row_t);
                                n_col    = CW'(col_t);
                                out_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                out_load = 1'b1;
                out_cell = r_rdata;
                n_state  = ST_IDLE;
            end
            ST_COPY: begin
                mem_re    = 1'b1;
                mem_raddr = r_addr;
                mem_we    = (r_addr != PW'(COLUMNS));
                mem_waddr = PW'(r_addr - PW'(COLUMNS) - 1'b1);
                mem_wdata = r_rdata;
                n_addr    = PW'(r_addr + 1'b1);
                if (r_addr == PW'(CELLS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                mem_we    = 1'b1;
                mem_waddr = PW'(CELLS - COLUMNS - 1);
                mem_wdata = r_rdata;
                n_addr    = PW'((ROWS - 1) * COLUMNS);
                n_state   = ST_FILL;
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = r_fill;
                n_addr    = PW'(r_addr + 1'b1);
                if (r_addr == PW'(CELLS - 1)) begin
                    n_state    = ST_IDLE;
                    n_init     = 1'b0;
                    out_load   = !r_init;
                    out_scroll = r_scroll;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        pos_next                 = PW'(PW'(n_row) * PW'(COLUMNS) + PW'(n_col));
        out_item.row_now         = 5'(n_row);
        out_item.column_now      = 7'(n_col);
        out_item.cursor_position = 11'(pos_next);
        out_item.cell_data       = out_cell;
        out_item.scrolled        = out_scroll;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_addr      <= '0;
            r_fill      <= {RESET_ATTR, BLANK_CHAR};
            r_init      <= 1'b1;
            r_scroll    <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_fill   <= n_fill;
            r_init   <= n_init;
            r_scroll <= n_scroll;
            r_row    <= n_row;
            r_col    <= n_col;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    assign o_init_busy = r_init;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/core/text_console_writer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console engine: screen memory of attribute/character cells,
// cursor handling, scrolling, clearing and cell reads behind a command queue.
// ----------------------------------------------------------------------------
// A cell read passes through ST_READ; a put that scrolls runs ST_COPY,
// ST_DRAIN and ST_FILL; a clear runs ST_FILL. Throughput: one item per
// cycle for puts that do not scroll and cursor sets while each result is
// taken; scroll and clear hold the single screen memory write port for a
// full walk. Reset: a clearing pass blanks the screen with attribute 0x0F;
// no item is accepted until it ends. Cursor resets to 0,0.
// ----------------------------------------------------------------------------
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]    r_attr;
    logic          push;
    t_cmd          push_cmd;
    t_cmd          q_cmd;
    t_queue_status q_status;
    logic          pop;
    logic          init_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (psel && penable && pwrite && (paddr[2] == REG_ATTR)) begin
            r_attr <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ATTR) ? {24'd0, r_attr} : 32'd0;

    tcw_front #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_front (
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_item     (i_in_item),
        .i_queue    (q_status),
        .i_init_busy(init_busy),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    tcw_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_cmd(push_cmd),
        .i_pop     (pop),
        .o_cmd     (q_cmd),
        .o_status  (q_status)
    );

    tcw_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_queue    (q_status),
        .i_cmd      (q_cmd),
        .o_pop      (pop),
        .i_attr     (r_attr),
        .o_init_busy(init_busy),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

endmodule

// ===== rtl/core/tcw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_item,
    input logic pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result dropped or changed while stalled");

    a_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.cursor_position ==
            11'(32'(o_out_item.row_now) * COLUMNS + 32'(o_out_item.column_now)))
        else $error("cursor position does not match row and column");

    a_scroll_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.scrolled |->
            o_out_item.column_now == 7'd0 && o_out_item.row_now == 5'(ROWS - 1))
        else $error("scroll left cursor away from start of last row");

    a_scroll_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.scrolled |-> o_out_item.cell_data == 16'd0)
        else $error("scrolling result carries cell data");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tcw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_item (o_out_item),
    .pready     (pready)
);
